// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W       = 32;
	localparam int COUNT_W       = 5;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP_FWD   = 3'd4,
		CMD_DUMP_REV   = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		DP_NONE       = 4'd0,
		DP_PUSH_FRONT = 4'd1,
		DP_PUSH_BACK  = 4'd2,
		DP_POP_FRONT  = 4'd3,
		DP_POP_BACK   = 4'd4,
		DP_DUMP_FWD   = 4'd5,
		DP_DUMP_REV   = 4'd6,
		DP_DUMP_STEP  = 4'd7,
		DP_CLEAR      = 4'd8
	} dp_op_t;

	typedef struct packed {
		logic    latch;
		dp_op_t  op;
		logic    emit;
		status_t status;
		logic    use_rdata;
		logic    last;
	} deq_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic last_item;
	} deq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_datapath.sv =====
// Datapath of the double-ended queue: ring store, pointers and result registers.
`default_nettype none

module deq_datapath #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic signed [deq_pkg::VALUE_W-1:0] push_value,
	input  wire deq_pkg::deq_ctl_t               ctl,
	output deq_pkg::deq_stat_t                   stat,
	output logic                                 result_strobe,
	output deq_pkg::status_t                     status,
	output logic signed [deq_pkg::VALUE_W-1:0]   out_value,
	output logic [deq_pkg::COUNT_W-1:0]          entry_count,
	output logic                                 last
);
	import deq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [OCC_W:0]   DEPTH_X  = (OCC_W + 1)'(DEPTH);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	// base + off stays below twice the depth, so one subtract wraps it
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [OCC_W-1:0] off);
		logic [OCC_W:0] sum;
		sum = (OCC_W + 1)'(base) + (OCC_W + 1)'(off);
		if (sum >= DEPTH_X)
			sum = sum - DEPTH_X;
		return sum[IDX_W-1:0];
	endfunction

	logic [IDX_W-1:0]   front_q, front_d;
	logic [OCC_W-1:0]   occ_q, occ_d;
	logic [IDX_W-1:0]   walk_q, walk_d;
	logic [OCC_W-1:0]   remain_q, remain_d;
	logic               dir_fwd_q, dir_fwd_d;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] rdata_q;
	logic [VALUE_W-1:0] mem [DEPTH];

	logic               we, re;
	logic [IDX_W-1:0]   waddr, raddr;
	logic [IDX_W-1:0]   back_idx;
	logic [OCC_W+COUNT_W-1:0] occ_ext;

	assign back_idx = ring_add(front_q, occ_q - 1'b1);

	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q == FULL_OCC);
	assign stat.last_item = (remain_q == OCC_W'(1));

	always_comb begin
		front_d   = front_q;
		occ_d     = occ_q;
		walk_d    = walk_q;
		remain_d  = remain_q;
		dir_fwd_d = dir_fwd_q;
		we        = 1'b0;
		re        = 1'b0;
		waddr     = front_q;
		raddr     = front_q;
		unique case (ctl.op)
			DP_PUSH_FRONT: begin
				front_d = ring_prev(front_q);
				waddr   = ring_prev(front_q);
				we      = 1'b1;
				occ_d   = occ_q + 1'b1;
			end
			DP_PUSH_BACK: begin
				waddr = ring_add(front_q, occ_q);
				we    = 1'b1;
				occ_d = occ_q + 1'b1;
			end
			DP_POP_FRONT: begin
				raddr   = front_q;
				re      = 1'b1;
				front_d = ring_next(front_q);
				occ_d   = occ_q - 1'b1;
			end
			DP_POP_BACK: begin
				raddr = back_idx;
				re    = 1'b1;
				occ_d = occ_q - 1'b1;
			end
			DP_DUMP_FWD: begin
				raddr     = front_q;
				re        = 1'b1;
				walk_d    = ring_next(front_q);
				remain_d  = occ_q;
				dir_fwd_d = 1'b1;
			end
			DP_DUMP_REV: begin
				raddr     = back_idx;
				re        = 1'b1;
				walk_d    = ring_prev(back_idx);
				remain_d  = occ_q;
				dir_fwd_d = 1'b0;
			end
			DP_DUMP_STEP: begin
				raddr    = walk_q;
				re       = 1'b1;
				walk_d   = dir_fwd_q ? ring_next(walk_q) : ring_prev(walk_q);
				remain_d = remain_q - 1'b1;
			end
			DP_CLEAR: begin
				front_d = '0;
				occ_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q       <= '0;
			occ_q         <= '0;
			walk_q        <= '0;
			remain_q      <= '0;
			dir_fwd_q     <= 1'b1;
			result_strobe <= 1'b0;
		end else begin
			front_q       <= front_d;
			occ_q         <= occ_d;
			walk_q        <= walk_d;
			remain_q      <= remain_d;
			dir_fwd_q     <= dir_fwd_d;
			result_strobe <= ctl.emit;
		end
	end

	// ring store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= value_q;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign occ_ext = {{COUNT_W{1'b0}}, occ_d};

	always_ff @(posedge clk) begin
		if (ctl.latch)
			value_q <= push_value;
		if (ctl.emit) begin
			status      <= ctl.status;
			out_value   <= ctl.use_rdata ? rdata_q : '0;
			entry_count <= occ_ext[COUNT_W-1:0];
			last        <= ctl.last;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/deq_ctrl.sv =====
// Controller state machine of the double-ended queue.
`default_nettype none

module deq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         command,
	input  wire deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_ctl_t       ctl,
	output logic                    busy
);
	import deq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EXEC    = 4'b0010,
		S_POP_OUT = 4'b0100,
		S_DUMP    = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] cmd_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		ctl.latch     = 1'b0;
		ctl.op        = DP_NONE;
		ctl.emit      = 1'b0;
		ctl.status    = ST_OK;
		ctl.use_rdata = 1'b0;
		ctl.last      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.emit = 1'b1;
				state_d  = S_IDLE;
				unique case (cmd_q)
					CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
						if (stat.full)
							ctl.status = ST_FULL;
						else
							ctl.op = (cmd_q == CMD_PUSH_FRONT) ? DP_PUSH_FRONT : DP_PUSH_BACK;
					end
					CMD_POP_FRONT, CMD_POP_BACK: begin
						if (stat.empty) begin
							ctl.status = ST_EMPTY;
						end else begin
							ctl.emit = 1'b0;
							ctl.op   = (cmd_q == CMD_POP_FRONT) ? DP_POP_FRONT : DP_POP_BACK;
							state_d  = S_POP_OUT;
						end
					end
					CMD_DUMP_FWD, CMD_DUMP_REV: begin
						if (stat.empty) begin
							ctl.status = ST_EMPTY;
						end else begin
							ctl.emit = 1'b0;
							ctl.op   = (cmd_q == CMD_DUMP_FWD) ? DP_DUMP_FWD : DP_DUMP_REV;
							state_d  = S_DUMP;
						end
					end
					CMD_CLEAR: begin
						ctl.op = DP_CLEAR;
					end
					default: begin
					end
				endcase
			end
			S_POP_OUT: begin
				ctl.emit      = 1'b1;
				ctl.use_rdata = 1'b1;
				state_d       = S_IDLE;
			end
			S_DUMP: begin
				// emit the entry read last cycle, fetch the next one
				ctl.emit      = 1'b1;
				ctl.use_rdata = 1'b1;
				ctl.last      = stat.last_item;
				ctl.op        = DP_DUMP_STEP;
				if (stat.last_item)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.latch)
				cmd_q <= command;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: controller and datapath.
`default_nettype none

// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries.
// Request channel: a request is taken at a rising edge with start high and
//   busy low; command and push_value are sampled there. Codes: push front,
//   push back, pop front, pop back, dump forward, dump reverse, clear.
// Result channel: each result sits on status, out_value, entry_count and
//   last for one cycle with result_strobe high. The receiver cannot stall,
//   so results are never held; last marks the final result of a request.
// Sequencing, from the accepting edge to the strobe:
//   push, clear, full push, empty pop/dump: S_EXEC, then the strobe; busy
//   drops in that same cycle, so no new request is taken before the strobe.
//   pop: the store read is registered, so S_POP_OUT follows S_EXEC.
//   dump of N entries: S_EXEC, then N results on consecutive cycles from
//   S_DUMP; busy drops with the last one. The single store read port sets
//   the one-result-per-cycle streaming rate.
// Reset (arst_n low) empties the queue and drops busy and result_strobe.
//   Store contents are not cleared; only entries written by a push are read.
// A push on a full queue is refused with the full status and no change.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [2:0]                         command,
	input  wire logic signed [deq_pkg::VALUE_W-1:0] push_value,
	output logic                                    busy,
	output logic                                    result_strobe,
	output logic [1:0]                              status,
	output logic signed [deq_pkg::VALUE_W-1:0]      out_value,
	output logic [deq_pkg::COUNT_W-1:0]             entry_count,
	output logic                                    last
);
	import deq_pkg::*;

	deq_ctl_t  ctl;
	deq_stat_t stat;
	status_t   status_w;

	// sequence each request: decode, issue store access, emit results
	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.ctl     (ctl),
		.busy    (busy)
	);

	// hold the ring store, the front pointer, the count and result registers
	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_value    (push_value),
		.ctl           (ctl),
		.stat          (stat),
		.result_strobe (result_strobe),
		.status        (status_w),
		.out_value     (out_value),
		.entry_count   (entry_count),
		.last          (last)
	);

	assign status = status_w;

endmodule

`default_nettype wire
